### rtl/core/isrt_pkg.sv
package isrt_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } isrt_state_t;

    typedef struct packed {
        logic load;
        logic sort_start;
        logic sort_step;
        logic emit_load;
        logic out_taken;
        logic clear;
    } isrt_cmd_t;

    typedef struct packed {
        logic sort_done;
        logic emit_done;
        logic out_valid;
        logic out_last;
    } isrt_sts_t;

endpackage

### rtl/core/isrt_dp.sv
module isrt_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  isrt_pkg::isrt_cmd_t                    cmd,
    output isrt_pkg::isrt_sts_t                    sts,
    input  logic signed [isrt_pkg::DATA_W-1:0]     in_value,
    output logic signed [isrt_pkg::DATA_W-1:0]     out_value,
    output logic                                   out_last,
    output logic                                   out_dropped
);

    logic signed [isrt_pkg::DATA_W-1:0] buf_reg  [isrt_pkg::DEPTH];
    logic signed [isrt_pkg::DATA_W-1:0] buf_next [isrt_pkg::DEPTH];

    logic [isrt_pkg::CNT_W-1:0] count_reg;
    logic [isrt_pkg::CNT_W-1:0] pass_reg;
    logic [isrt_pkg::CNT_W-1:0] emit_idx_reg;
    logic                       overflow_reg;
    logic                       phase_reg;
    logic                       out_valid_reg;
    logic signed [isrt_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_last_reg;
    logic                       out_dropped_reg;

    logic full;

    assign full = (count_reg == isrt_pkg::CNT_W'(isrt_pkg::DEPTH));

    // one odd-even transposition round over the occupied entries
    always_comb begin
        for (int i = 0; i < isrt_pkg::DEPTH; i++) begin
            buf_next[i] = buf_reg[i];
        end
        for (int i = 0; i < isrt_pkg::DEPTH - 1; i++) begin
            if ((1'(i) == phase_reg) && (isrt_pkg::CNT_W'(i + 1) < count_reg)
                    && (buf_reg[i] > buf_reg[i + 1])) begin
                buf_next[i]     = buf_reg[i + 1];
                buf_next[i + 1] = buf_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sort_step) begin
            for (int i = 0; i < isrt_pkg::DEPTH; i++) begin
                buf_reg[i] <= buf_next[i];
            end
        end else if (cmd.load && !full) begin
            buf_reg[count_reg[isrt_pkg::IDX_W-1:0]] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            pass_reg      <= '0;
            phase_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                emit_idx_reg <= '0;
            end else if (cmd.load) begin
                if (full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.sort_start) begin
                pass_reg  <= '0;
                phase_reg <= 1'b0;
            end else if (cmd.sort_step) begin
                pass_reg  <= pass_reg + 1'b1;
                phase_reg <= ~phase_reg;
            end
            if (cmd.emit_load) begin
                emit_idx_reg  <= emit_idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (cmd.out_taken) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_data_reg    <= buf_reg[emit_idx_reg[isrt_pkg::IDX_W-1:0]];
            out_last_reg    <= ((emit_idx_reg + 1'b1) == count_reg);
            out_dropped_reg <= overflow_reg;
        end
    end

    assign sts.sort_done = (pass_reg == count_reg);
    assign sts.emit_done = (emit_idx_reg == count_reg);
    assign sts.out_valid = out_valid_reg;
    assign sts.out_last  = out_last_reg;

    assign out_value   = out_data_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_dropped_reg;

endmodule

### rtl/core/isrt_ctrl.sv
module isrt_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic                    in_last,
    output logic                    in_ready,
    input  logic                    out_ready,
    input  isrt_pkg::isrt_sts_t     sts,
    output isrt_pkg::isrt_cmd_t     cmd
);

    isrt_pkg::isrt_state_t state_reg;
    isrt_pkg::isrt_state_t state_next;

    logic in_fire;
    logic out_fire;

    assign in_fire  = (state_reg == isrt_pkg::ST_LOAD) && in_valid;
    assign out_fire = sts.out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isrt_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            isrt_pkg::ST_LOAD: begin
                if (in_fire && in_last) begin
                    state_next = isrt_pkg::ST_SORT;
                end
            end
            isrt_pkg::ST_SORT: begin
                if (sts.sort_done) begin
                    state_next = isrt_pkg::ST_EMIT;
                end
            end
            isrt_pkg::ST_EMIT: begin
                if (out_fire && sts.out_last) begin
                    state_next = isrt_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = isrt_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.out_taken  = out_fire;
        unique case (state_reg)
            isrt_pkg::ST_LOAD: begin
                in_ready       = 1'b1;
                cmd.load       = in_valid;
                cmd.sort_start = in_fire && in_last;
            end
            isrt_pkg::ST_SORT: begin
                cmd.sort_step = !sts.sort_done;
            end
            isrt_pkg::ST_EMIT: begin
                cmd.emit_load = !sts.emit_done && (!sts.out_valid || out_ready);
                cmd.clear     = out_fire && sts.out_last;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/integer_array_sorter.sv
// Channel  | Ports                        | Contents (lowest bit first)
// ---------+------------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata    | tdata: value[31:0]; tlast: last
//          | s_tlast                      |
// output   | m_tvalid m_tready m_tdata    | tdata: sorted_value[31:0];
//          | m_tlast m_tuser              | tlast: end_of_set; tuser: dropped
//
// A set of n stored values is loaded as the values are accepted, sorted by n rounds
// (one odd-even transposition round per cycle over the buffer registers), and then
// sent out in ascending order through the output register.
// Reset is synchronous and active low; it empties the buffer count and the flag.
// Input is accepted only while loading; output stalls hold the output register.
module integer_array_sorter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sorted_value[31:0]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // dropped
);

    isrt_pkg::isrt_cmd_t cmd;
    isrt_pkg::isrt_sts_t sts;

    logic signed [isrt_pkg::DATA_W-1:0] out_value;
    logic                               out_dropped;

    isrt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    isrt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_value    (s_tdata),
        .out_value   (out_value),
        .out_last    (m_tlast),
        .out_dropped (out_dropped)
    );

    assign m_tvalid   = sts.out_valid;
    assign m_tdata    = out_value;
    assign m_tuser[0] = out_dropped;

endmodule
